// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lobtd_pkg.sv
// Package of the laser-off and beam-trip detector: word types, register
// indexes, event codes and reset values. No dependencies.
`default_nettype none

package lobtd_pkg;

   localparam int POS_BITS      = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 18;
   localparam int CNT_BITS      = 17;
   localparam int RCV_BITS      = 16;
   localparam int KINDS         = 4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LASER_OFF_LEVEL = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LASER_MIN_RUN   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BEAM_TRIP_LEVEL = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BEAM_CEILING    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIP_CONFIRM    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIP_BACKDATE   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECOVER_WAIT    = 3'd6;

   // event codes; bit k of an event mask stands for code k
   localparam logic [1:0] EVT_LASER_OFF_BEGIN = 2'd0;
   localparam logic [1:0] EVT_LASER_OFF_END   = 2'd1;
   localparam logic [1:0] EVT_TRIP_BEGIN      = 2'd2;
   localparam logic [1:0] EVT_BEAM_RECOVERED  = 2'd3;

   typedef struct packed {
      logic [17:0] laser_power;
      logic [15:0] beam_current;
      logic        end_of_run;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          event_kind;
      logic [POS_BITS-1:0] position;
      logic                last_of_item;
   } rsp_word_type;

   typedef struct packed {
      logic [17:0] laser_off_level;
      logic [15:0] laser_min_run;
      logic [15:0] beam_trip_level;
      logic [15:0] beam_ceiling;
      logic [15:0] trip_confirm;
      logic [15:0] trip_backdate;
      logic [15:0] recover_wait;
   } cfg_type;

   typedef struct packed {
      logic [KINDS-1:0]               mask;
      logic [KINDS-1:0][POS_BITS-1:0] pos;
   } event_set_type;

   localparam cfg_type CFG_RESET = '{
      laser_off_level: 18'd0,
      laser_min_run:   16'd240,
      beam_trip_level: 16'd0,
      beam_ceiling:    16'd65535,
      trip_confirm:    16'd10,
      trip_backdate:   16'd480,
      recover_wait:    16'd480
   };

endpackage

`default_nettype wire

// File: hdl/lobtd_csr.sv
// Configuration register file of the detector.
// Depends on lobtd_pkg.
`default_nettype none

module lobtd_csr import lobtd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LASER_OFF_LEVEL: cfg_in.laser_off_level = csr_data;
            CSR_LASER_MIN_RUN:   cfg_in.laser_min_run   = csr_data[15:0];
            CSR_BEAM_TRIP_LEVEL: cfg_in.beam_trip_level = csr_data[15:0];
            CSR_BEAM_CEILING:    cfg_in.beam_ceiling    = csr_data[15:0];
            CSR_TRIP_CONFIRM:    cfg_in.trip_confirm    = csr_data[15:0];
            CSR_TRIP_BACKDATE:   cfg_in.trip_backdate   = csr_data[15:0];
            CSR_RECOVER_WAIT:    cfg_in.recover_wait    = csr_data[15:0];
            default:             cfg_in = cfg_ff;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lobtd_core.sv
// Input register, run state and event decision of the detector.
// Depends on lobtd_pkg.
`default_nettype none

module lobtd_core import lobtd_pkg::*; #(
   parameter int INDEX_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_word_type  req_data,
   input  wire cfg_type       cfg,
   input  wire logic          out_free,
   output logic               evt_load,
   output event_set_type      evt_set
);

   localparam int IDX_EXT = INDEX_BITS + 1;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [RCV_BITS-1:0] RCV_MAX = '1;

   logic                  in_valid_ff, in_valid_in;
   req_word_type          in_word_ff;
   logic [INDEX_BITS-1:0] idx_ff;
   logic [CNT_BITS-1:0]   loff_cnt_ff, trip_cnt_ff;
   logic [RCV_BITS-1:0]   rcv_cnt_ff;
   logic                  loff_open_ff, trip_open_ff;

   logic                  advance, eor;
   logic [CNT_BITS-1:0]   loff_cnt_nx, loff_cnt_sat, trip_cnt_nx, trip_inc, back;
   logic [RCV_BITS-1:0]   rcv_cnt_nx, rcv_inc;
   logic                  loff_open_nx, open_mid, begin_hit, end_hit;
   logic                  good, trip, trip_hit, rcv_hit, trip_open_mid, trip_open_nx;
   logic [INDEX_BITS-1:0] begin_pos, trip_pos;

   assign advance   = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign eor       = in_word_ff.end_of_run;

   // laser-off run
   always_comb begin
      loff_cnt_sat = (loff_cnt_ff == CNT_MAX) ? loff_cnt_ff : loff_cnt_ff + CNT_BITS'(1);
      loff_cnt_nx  = (in_word_ff.laser_power <= cfg.laser_off_level) ? loff_cnt_sat : '0;
      begin_hit    = (loff_cnt_nx == CNT_BITS'(cfg.laser_min_run));
      begin_pos    = idx_ff - INDEX_BITS'(cfg.laser_min_run) + INDEX_BITS'(1);
      open_mid     = loff_open_ff | begin_hit;
      end_hit      = open_mid & ((loff_cnt_nx == '0) | eor);
      loff_open_nx = open_mid & ~end_hit;
   end

   // beam trip and recovery
   always_comb begin
      good = (in_word_ff.beam_current > cfg.beam_trip_level) &&
             (in_word_ff.beam_current < cfg.beam_ceiling);
      trip = (in_word_ff.beam_current <= cfg.beam_trip_level) &&
             (in_word_ff.beam_current != '0);
      back = CNT_BITS'(cfg.trip_backdate) + CNT_BITS'(cfg.trip_confirm);
      // backdate by the full amount unless that would pass sample zero
      trip_pos = ({1'b0, idx_ff} >= IDX_EXT'(back)) ? idx_ff - INDEX_BITS'(back)
                                                    : idx_ff - INDEX_BITS'(cfg.trip_confirm);
      trip_inc = (trip_cnt_ff == CNT_MAX) ? trip_cnt_ff : trip_cnt_ff + CNT_BITS'(1);
      rcv_inc  = (rcv_cnt_ff == RCV_MAX) ? rcv_cnt_ff : rcv_cnt_ff + RCV_BITS'(1);

      trip_cnt_nx   = trip_cnt_ff;
      rcv_cnt_nx    = rcv_cnt_ff;
      trip_open_mid = trip_open_ff;
      trip_hit      = 1'b0;
      rcv_hit       = 1'b0;
      if (!trip_open_ff) begin
         if (trip) begin
            if (trip_inc > CNT_BITS'(cfg.trip_confirm)) begin
               trip_cnt_nx   = '0;
               rcv_cnt_nx    = '0;
               trip_hit      = 1'b1;
               trip_open_mid = 1'b1;
            end else begin
               trip_cnt_nx = trip_inc;
            end
         end else begin
            trip_cnt_nx = '0;
         end
      end else begin
         if (good) begin
            if (rcv_inc >= cfg.recover_wait) begin
               rcv_cnt_nx    = '0;
               rcv_hit       = 1'b1;
               trip_open_mid = 1'b0;
            end else begin
               rcv_cnt_nx = rcv_inc;
            end
         end else begin
            rcv_cnt_nx = '0;
         end
      end
      trip_open_nx = trip_open_mid & ~eor;
   end

   assign evt_load = advance;
   always_comb begin
      evt_set.mask = {rcv_hit | (eor & trip_open_mid), trip_hit, end_hit, begin_hit};
      evt_set.pos[EVT_LASER_OFF_BEGIN] = POS_BITS'(begin_pos);
      evt_set.pos[EVT_LASER_OFF_END]   = POS_BITS'(idx_ff);
      evt_set.pos[EVT_TRIP_BEGIN]      = POS_BITS'(trip_pos);
      evt_set.pos[EVT_BEAM_RECOVERED]  = POS_BITS'(idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         loff_cnt_ff  <= '0;
         loff_open_ff <= 1'b0;
         trip_cnt_ff  <= '0;
         rcv_cnt_ff   <= '0;
         trip_open_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            if (eor) begin
               idx_ff       <= '0;
               loff_cnt_ff  <= '0;
               loff_open_ff <= 1'b0;
               trip_cnt_ff  <= '0;
               rcv_cnt_ff   <= '0;
               trip_open_ff <= 1'b0;
            end else begin
               idx_ff       <= idx_ff + INDEX_BITS'(1);
               loff_cnt_ff  <= loff_cnt_nx;
               loff_open_ff <= loff_open_nx;
               trip_cnt_ff  <= trip_cnt_nx;
               rcv_cnt_ff   <= rcv_cnt_nx;
               trip_open_ff <= trip_open_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lobtd_out.sv
// Result register of the detector: holds one sample's events and sends
// them one word at a time, lowest code first. Depends on lobtd_pkg.
`default_nettype none

module lobtd_out import lobtd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          evt_load,
   input  wire event_set_type evt_set,
   output logic               out_free,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_word_type       rsp_data
);

   logic [KINDS-1:0]               mask_ff, mask_in, mask_rest;
   logic [KINDS-1:0][POS_BITS-1:0] pos_ff;
   logic [1:0]                     kind;
   logic                           last;

   always_comb begin
      kind = EVT_LASER_OFF_BEGIN;
      for (int k = KINDS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            kind = 2'(k);
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - KINDS'(1));  // drop lowest set bit
   assign last      = (mask_rest == '0);
   assign rsp_valid = |mask_ff;
   assign out_free  = (mask_ff == '0) | (last & rsp_ready);

   assign rsp_data.event_kind   = kind;
   assign rsp_data.position     = pos_ff[kind];
   assign rsp_data.last_of_item = last;

   always_comb begin
      mask_in = mask_ff;
      if (evt_load) begin
         mask_in = evt_set.mask;
      end else if (rsp_valid && rsp_ready) begin
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_load) begin
         pos_ff <= evt_set.pos;
      end
   end

endmodule

`default_nettype wire

// File: hdl/laser_off_and_beam_trip_detector_top.sv
// Laser-off and beam-trip detector. Each req word is one sample (laser power,
// beam current, end-of-run flag); samples are numbered from zero and the
// numbering restarts after a sample flagged end_of_run, which also closes any
// open laser-off period or trip and returns all run state to reset (the
// configuration registers are kept). Every sample gives zero to four rsp words,
// in code order: laser off begins, laser off ends, trip begins, beam recovered;
// the last word of a sample carries last_of_item. Rate: one sample per clock
// while each sample gives at most one word and rsp_ready stays high; a sample
// that gives n words holds the result register until all n are taken, and the
// input register takes the next sample meanwhile. Configuration is written
// through the csr port, one register per word; the user must write it only while
// the block is idle, which the block does not enforce; csr_ready is always high.
// Depends on lobtd_pkg, lobtd_csr, lobtd_core, lobtd_out.
`default_nettype none

module laser_off_and_beam_trip_detector_top import lobtd_pkg::*; #(
   parameter int INDEX_BITS = 32   // sample counter width, 16 to 48
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // sample words
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_word_type             req_data,
   // event words
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_word_type                  rsp_data,
   // configuration writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   cfg_type       cfg;
   event_set_type evt_set;
   logic          evt_load;
   logic          out_free;

   // register file
   lobtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register, counters and the per-sample event decision
   lobtd_core #(
      .INDEX_BITS (INDEX_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .out_free  (out_free),
      .evt_load  (evt_load),
      .evt_set   (evt_set)
   );

   // result register; frees itself as the last word of a sample is taken
   lobtd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .evt_load  (evt_load),
      .evt_set   (evt_set),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/lobtd_checker.sv
// Port-level checks of the detector and their bind to the top level.
// Depends on lobtd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lobtd_checker import lobtd_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_data
);

   property p_reset_empties;
      reset |=> !rsp_valid;
   endproperty

   property p_idle_takes_input;
      !rsp_valid |-> req_ready;
   endproperty

   property p_burst_in_order;
      rsp_valid && rsp_ready && !rsp_data.last_of_item
         |=> rsp_valid && (rsp_data.event_kind > $past(rsp_data.event_kind));
   endproperty

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data);
   endproperty

   `ASSERT_CLK_ALWAYS(a_reset_empties, clock, p_reset_empties, "words pending after reset")

   `ASSERT_CLK(a_idle_takes_input, clock, reset, p_idle_takes_input, "input blocked, output empty")

   `ASSERT_CLK(a_burst_in_order, clock, reset, p_burst_in_order, "sample words out of order")

   `ASSERT_CLK(a_rsp_hold, clock, reset, p_rsp_hold, "stalled word changed")

endmodule

bind laser_off_and_beam_trip_detector_top lobtd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: dv/tb_laser_off_and_beam_trip_detector_top.sv
// Testbench for laser_off_and_beam_trip_detector_top: drives sample words,
// predicts the event words and checks every one of them in order.
// Depends on lobtd_pkg and the detector RTL only.
`timescale 1ns / 1ps

module tb_laser_off_and_beam_trip_detector_top;
   import lobtd_pkg::*;

   localparam int unsigned MAX_POWER     = 262143;
   localparam int unsigned MAX_CURRENT   = 65535;
   localparam int unsigned SETTLE_CYCLES = 10;      // pipeline depth plus margin
   localparam int unsigned CYCLE_LIMIT   = 200000;  // far above the slowest legal run
   localparam int unsigned RANDOM_PHASES = 7;
   localparam int unsigned PHASE_WORDS   = 22;

   // index 7 has no register behind it; writes there must be ignored
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;

   // shape of the beam current in the random sample stream
   typedef enum {BEAM_ZERO, BEAM_TRIP, BEAM_GOOD, BEAM_HIGH} beam_shape_type;

   // ------------------------------------------------------------------
   // Event predictor and in-order checker
   // ------------------------------------------------------------------
   class event_tracker;
      cfg_type              cfg;
      logic [POS_BITS-1:0]  run_index;
      logic [CNT_BITS-1:0]  off_count;
      logic                 off_open;
      logic [CNT_BITS-1:0]  trip_run;
      logic [RCV_BITS-1:0]  recover_run;
      logic                 trip_open;
      rsp_word_type         pending_events[$];
      int unsigned          errors;
      int unsigned          samples;
      int unsigned          checked;
      int unsigned          kind_count[KINDS];

      function new();
         cfg = CFG_RESET;
         errors = 0;
         samples = 0;
         checked = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
         clear_run();
      endfunction

      function void clear_run();
         run_index   = '0;
         off_count   = '0;
         off_open    = 1'b0;
         trip_run    = '0;
         recover_run = '0;
         trip_open   = 1'b0;
      endfunction

      function int outstanding();
         return pending_events.size();
      endfunction

      // appends one expected word at the tail
      function void queue_event(rsp_word_type w);
         pending_events.insert(pending_events.size(), w);
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_LASER_OFF_LEVEL: cfg.laser_off_level = data;
            CSR_LASER_MIN_RUN:   cfg.laser_min_run   = data[15:0];
            CSR_BEAM_TRIP_LEVEL: cfg.beam_trip_level = data[15:0];
            CSR_BEAM_CEILING:    cfg.beam_ceiling    = data[15:0];
            CSR_TRIP_CONFIRM:    cfg.trip_confirm    = data[15:0];
            CSR_TRIP_BACKDATE:   cfg.trip_backdate   = data[15:0];
            CSR_RECOVER_WAIT:    cfg.recover_wait    = data[15:0];
            default: ;
         endcase
      endfunction

      // Works out the events of one accepted sample and queues them.
      function void note_sample(req_word_type s);
         logic [POS_BITS-1:0] idx;
         logic [CNT_BITS-1:0] backdate_sum;
         logic [POS_BITS-1:0] start_pos;
         logic                good;
         logic                trip;
         int                  made;
         idx  = run_index;
         made = 0;
         samples++;

         // laser-off periods
         if (s.laser_power <= cfg.laser_off_level) begin
            if (off_count != {CNT_BITS{1'b1}}) off_count++;
         end else begin
            off_count = '0;
         end
         if (off_count == cfg.laser_min_run) begin
            start_pos = idx - POS_BITS'(cfg.laser_min_run) + POS_BITS'(1);
            queue_event(rsp_word_type'{EVT_LASER_OFF_BEGIN, start_pos, 1'b0});
            made++;
            off_open = 1'b1;
         end
         if (off_open && (off_count == '0 || s.end_of_run)) begin
            queue_event(rsp_word_type'{EVT_LASER_OFF_END, idx, 1'b0});
            made++;
            off_open = 1'b0;
         end

         // beam trips
         good = (s.beam_current > cfg.beam_trip_level) && (s.beam_current < cfg.beam_ceiling);
         trip = (s.beam_current <= cfg.beam_trip_level) && (s.beam_current != '0);
         if (!trip_open) begin
            if (trip) begin
               if (trip_run != {CNT_BITS{1'b1}}) trip_run++;
               if (trip_run > cfg.trip_confirm) begin
                  backdate_sum = {1'b0, cfg.trip_backdate} + {1'b0, cfg.trip_confirm};
                  // near the run start the extra backdate is dropped
                  start_pos = (idx >= backdate_sum) ? idx - POS_BITS'(backdate_sum)
                                                    : idx - POS_BITS'(cfg.trip_confirm);
                  trip_run = '0;
                  queue_event(rsp_word_type'{EVT_TRIP_BEGIN, start_pos, 1'b0});
                  made++;
                  trip_open   = 1'b1;
                  recover_run = '0;
               end
            end else begin
               trip_run = '0;
            end
         end else begin
            if (good) begin
               if (recover_run != {RCV_BITS{1'b1}}) recover_run++;
               if (recover_run >= cfg.recover_wait) begin
                  recover_run = '0;
                  queue_event(rsp_word_type'{EVT_BEAM_RECOVERED, idx, 1'b0});
                  made++;
                  trip_open = 1'b0;
               end
            end else begin
               recover_run = '0;
            end
         end

         // the run end closes an open trip
         if (s.end_of_run && trip_open) begin
            queue_event(rsp_word_type'{EVT_BEAM_RECOVERED, idx, 1'b0});
            made++;
            trip_open = 1'b0;
         end

         if (made > 0) begin
            pending_events[pending_events.size() - 1].last_of_item = 1'b1;
         end

         if (s.end_of_run) clear_run();
         else run_index = idx + POS_BITS'(1);
      endfunction

      function void check_event(rsp_word_type got);
         rsp_word_type want;
         if (pending_events.size() == 0) begin
            errors++;
            $display("%0t: event word with nothing expected: kind %0d position %0d last %0b",
                     $time, got.event_kind, got.position, got.last_of_item);
            return;
         end
         want = pending_events.pop_front();
         checked++;
         kind_count[want.event_kind]++;
         if (got.event_kind !== want.event_kind) begin
            errors++;
            $display("%0t: event_kind mismatch: expected %0d actual %0d",
                     $time, want.event_kind, got.event_kind);
         end
         if (got.position !== want.position) begin
            errors++;
            $display("%0t: position mismatch (kind %0d): expected %0d actual %0d",
                     $time, want.event_kind, want.position, got.position);
         end
         if (got.last_of_item !== want.last_of_item) begin
            errors++;
            $display("%0t: last_of_item mismatch (kind %0d): expected %0b actual %0b",
                     $time, want.event_kind, want.last_of_item, got.last_of_item);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and block under test
   // ------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_word_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_word_type             rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   laser_off_and_beam_trip_detector_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   event_tracker sb = new();

   int unsigned    burst_left = 0;      // words left in the current sender burst
   int unsigned    settings_applied = 0;
   int unsigned    cycle_count = 0;
   // random stream shaping: runs of laser off/on and of one beam shape
   int unsigned    laser_left = 0;
   bit             laser_off = 1'b0;
   int unsigned    beam_left = 0;
   beam_shape_type beam_shape = BEAM_GOOD;

   // ------------------------------------------------------------------
   // Handshake monitor. Everything is sampled at the rising edge, before
   // the driver's nonblocking updates land, so ordering within the step
   // does not matter.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_event(rsp_data);
      end
   end

   // Receiver: ready follows a rotating 8-bit pattern, reloaded whenever
   // pattern_age wraps. Sometimes all ones (no stalls), else random with bit 0
   // set, so the pattern is never all zeros.
   logic [7:0]  ready_pattern = 8'hFF;
   int unsigned pattern_age = 0;

   always @(posedge clock) begin
      if (pattern_age == 63) begin
         pattern_age   <= 0;
         ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
         pattern_age   <= pattern_age + 1;
         ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
      end
      rsp_ready <= ready_pattern[0];
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: cycle limit hit, %0d event words still expected",
               $time, sb.outstanding());
      $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Sends one sample word. Valid stays up across a burst; at the end of a
   // burst the sender drops valid for a random gap and picks a new burst.
   task automatic send_sample(input req_word_type w);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // mostly short bursts, now and then a long back-to-back stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                  : $urandom_range(0, 5);
      end
   endtask

   task automatic send_fields(input int unsigned power, input int unsigned cur, input bit eor);
      req_word_type s;
      s.laser_power  = 18'(power);
      s.beam_current = 16'(cur);
      s.end_of_run   = eor;
      send_sample(s);
   endtask

   // Holds off the sender until every expected event has come back, then
   // lets the pipeline empty of samples that give no event.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register. The 16-bit ones get random junk in the two
   // upper data bits, which the block must drop.
   task automatic apply_settings(input cfg_type c);
      write_csr(CSR_LASER_OFF_LEVEL, c.laser_off_level);
      write_csr(CSR_LASER_MIN_RUN,   {2'($urandom), c.laser_min_run});
      write_csr(CSR_BEAM_TRIP_LEVEL, {2'($urandom), c.beam_trip_level});
      write_csr(CSR_BEAM_CEILING,    {2'($urandom), c.beam_ceiling});
      write_csr(CSR_TRIP_CONFIRM,    {2'($urandom), c.trip_confirm});
      write_csr(CSR_TRIP_BACKDATE,   {2'($urandom), c.trip_backdate});
      write_csr(CSR_RECOVER_WAIT,    {2'($urandom), c.recover_wait});
      write_csr(CSR_UNUSED_INDEX,    18'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Small counts and waits so that periods, trips and recoveries happen
   // within a few dozen samples.
   function automatic cfg_type random_settings();
      cfg_type c;
      c.laser_off_level = ($urandom_range(0, 1) == 0) ? 18'($urandom_range(0, 2000))
                                                      : 18'($urandom);
      c.laser_min_run   = 16'($urandom_range(0, 6));
      c.beam_trip_level = 16'($urandom_range(1, MAX_CURRENT - 1));
      // usually above the trip level, but a ceiling at or under it is legal
      c.beam_ceiling    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                        : 16'($urandom_range(c.beam_trip_level, MAX_CURRENT));
      c.trip_confirm    = 16'($urandom_range(0, 5));
      c.trip_backdate   = 16'($urandom_range(0, 40));
      c.recover_wait    = 16'($urandom_range(0, 5));
      return c;
   endfunction

   function automatic int unsigned run_cap(input int unsigned n);
      return (n > 12) ? 12 : n;
   endfunction

   // Next random sample: runs of laser off/on long enough to confirm a
   // period, runs of trip/good/high/zero current sized to the current
   // confirm and recovery counts, plus some pure noise and run ends.
   function automatic req_word_type next_sample();
      req_word_type s;
      int unsigned  lvl;
      int unsigned  tl;
      int unsigned  ce;
      int unsigned  lo;
      int unsigned  pick;
      int unsigned  cur;
      lvl = sb.cfg.laser_off_level;
      tl  = sb.cfg.beam_trip_level;
      ce  = sb.cfg.beam_ceiling;

      if (laser_left == 0) begin
         laser_off  = ($urandom_range(0, 2) != 0);
         laser_left = laser_off ? $urandom_range(1, run_cap(sb.cfg.laser_min_run + 3))
                                : $urandom_range(1, 6);
      end
      laser_left--;

      if (beam_left == 0) begin
         pick = $urandom_range(0, 19);
         if (pick < 8)       beam_shape = BEAM_TRIP;
         else if (pick < 15) beam_shape = BEAM_GOOD;
         else if (pick < 18) beam_shape = BEAM_HIGH;
         else                beam_shape = BEAM_ZERO;
         case (beam_shape)
            BEAM_TRIP: beam_left = $urandom_range(1, run_cap(sb.cfg.trip_confirm + 3));
            BEAM_GOOD: beam_left = $urandom_range(1, run_cap(sb.cfg.recover_wait + 2));
            default:   beam_left = $urandom_range(1, 4);
         endcase
      end
      beam_left--;

      // laser power, with the off level itself and one above it often hit
      if (laser_off) begin
         s.laser_power = ($urandom_range(0, 3) == 0) ? 18'(lvl) : 18'($urandom_range(0, lvl));
      end else if (lvl == MAX_POWER) begin
         s.laser_power = 18'(MAX_POWER);
      end else begin
         s.laser_power = ($urandom_range(0, 3) == 0) ? 18'(lvl + 1)
                                                     : 18'($urandom_range(lvl + 1, MAX_POWER));
      end

      case (beam_shape)
         BEAM_TRIP: begin
            if (tl == 0) cur = 0;
            else if ($urandom_range(0, 3) == 0) cur = ($urandom_range(0, 1) == 0) ? 1 : tl;
            else cur = $urandom_range(1, tl);
         end
         BEAM_GOOD: begin
            if (ce > tl + 1) cur = $urandom_range(tl + 1, ce - 1);
            else cur = $urandom_range(0, MAX_CURRENT);
         end
         BEAM_HIGH: begin
            lo  = (ce > tl) ? ce : tl + 1;
            cur = (lo > MAX_CURRENT) ? MAX_CURRENT : $urandom_range(lo, MAX_CURRENT);
         end
         default: cur = 0;
      endcase
      s.beam_current = 16'(cur);

      // noise breaks runs at random
      if ($urandom_range(0, 9) == 0) begin
         s.laser_power  = 18'($urandom);
         s.beam_current = 16'($urandom);
      end
      s.end_of_run = ($urandom_range(0, 24) == 0);
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: field extremes and a run end. Trip level 0 and a
      // run of 240 mean none of these may give an event.
      send_fields(0, 0, 1'b0);
      send_fields(MAX_POWER, MAX_CURRENT, 1'b0);
      send_fields(0, 1, 1'b1);
      wait_idle();

      // Small counts: laser-off period and trip begin on one sample, end on
      // the first power above the level, recovery after two good samples,
      // ceiling current is not good, a second trip far enough in to take the
      // full backdate, then a run end closing both the period and the trip.
      c = '{laser_off_level: 18'd1000, laser_min_run: 16'd3, beam_trip_level: 16'd100,
            beam_ceiling: 16'd5000, trip_confirm: 16'd2, trip_backdate: 16'd4,
            recover_wait: 16'd2};
      apply_settings(c);
      send_fields(1000, 100, 1'b0);
      send_fields(1000, 100, 1'b0);
      send_fields(1000, 100, 1'b0);
      send_fields(1001, 4999, 1'b0);
      send_fields(MAX_POWER, 101, 1'b0);
      send_fields(0, 5000, 1'b0);
      send_fields(0, 1, 1'b0);
      send_fields(0, 1, 1'b0);
      send_fields(0, 1, 1'b0);
      send_fields(0, 4999, 1'b1);
      wait_idle();

      // Zero run and zero recovery wait: every on sample opens and closes a
      // period, the first good sample recovers, and a trip confirmed on a
      // run-end sample gives all four events at once.
      c = '{laser_off_level: 18'd500, laser_min_run: 16'd0, beam_trip_level: 16'd20,
            beam_ceiling: 16'd65535, trip_confirm: 16'd0, trip_backdate: 16'd65535,
            recover_wait: 16'd0};
      apply_settings(c);
      send_fields(501, 20, 1'b0);
      send_fields(501, 21, 1'b0);
      send_fields(501, 5, 1'b1);
      send_fields(0, MAX_CURRENT, 1'b0);
      send_fields(501, 0, 1'b0);
      wait_idle();

      // Random phases: all-ones and all-zeros settings among random ones.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 1)      c = '1;
         else if (p == 2) c = '0;
         else             c = random_settings();
         apply_settings(c);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // once mid-phase, hold the sender until all events are back
            if (p == 3 && n == PHASE_WORDS / 2) wait_idle();
            send_sample(next_sample());
         end
         wait_idle();
      end

      $display("Ran %0d samples under %0d register settings, %0d event words checked",
               sb.samples, settings_applied, sb.checked);
      $display("Events: %0d laser-off begins, %0d ends, %0d trip begins, %0d recoveries",
               sb.kind_count[EVT_LASER_OFF_BEGIN], sb.kind_count[EVT_LASER_OFF_END],
               sb.kind_count[EVT_TRIP_BEGIN], sb.kind_count[EVT_BEAM_RECOVERED]);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
